/* sv/sit_pkg.sv */
// Segment intersection test: shared types and constants.
// No dependencies; used by every module of the core.
package sit_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned OUT_TDATA_W     = 8;
  localparam int unsigned N_CROSS         = 4;

  typedef struct packed {
    logic s2;
    logic s3;
  } stage_en_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } sign_t;

endpackage

/* sv/sit_pre.sv */
// Segment intersection test, first stage: endpoint differences and range overlap.
// Depends on sit_pkg.
module sit_pre #(
  parameter int unsigned COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [8*COORD_WIDTH-1:0]     coords,
  output logic signed [COORD_WIDTH:0]  ln_dx_r [sit_pkg::N_CROSS],
  output logic signed [COORD_WIDTH:0]  ln_dy_r [sit_pkg::N_CROSS],
  output logic signed [COORD_WIDTH:0]  pt_dx_r [sit_pkg::N_CROSS],
  output logic signed [COORD_WIDTH:0]  pt_dy_r [sit_pkg::N_CROSS],
  output logic                         rng_r
);

  localparam int unsigned W = COORD_WIDTH;

  // order: a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  logic signed [W-1:0] c [8];
  logic signed [W:0]   e [8];
  logic signed [W:0]   ln_dx_nxt [sit_pkg::N_CROSS];
  logic signed [W:0]   ln_dy_nxt [sit_pkg::N_CROSS];
  logic signed [W:0]   pt_dx_nxt [sit_pkg::N_CROSS];
  logic signed [W:0]   pt_dy_nxt [sit_pkg::N_CROSS];
  logic                meet_x, meet_y, rng_nxt;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      c[i] = $signed(coords[i*W +: W]);
      e[i] = (W+1)'(c[i]);
    end
  end

  // value = ln_dy * pt_dx - ln_dx * pt_dy, points taken relative to the line start
  always_comb begin
    ln_dx_nxt[0] = e[2] - e[0];  ln_dy_nxt[0] = e[3] - e[1];
    pt_dx_nxt[0] = e[4] - e[0];  pt_dy_nxt[0] = e[5] - e[1];
    ln_dx_nxt[1] = e[2] - e[0];  ln_dy_nxt[1] = e[3] - e[1];
    pt_dx_nxt[1] = e[6] - e[0];  pt_dy_nxt[1] = e[7] - e[1];
    ln_dx_nxt[2] = e[6] - e[4];  ln_dy_nxt[2] = e[7] - e[5];
    pt_dx_nxt[2] = e[0] - e[4];  pt_dy_nxt[2] = e[1] - e[5];
    ln_dx_nxt[3] = e[6] - e[4];  ln_dy_nxt[3] = e[7] - e[5];
    pt_dx_nxt[3] = e[2] - e[4];  pt_dy_nxt[3] = e[3] - e[5];
  end

  assign meet_x = (c[0] >= c[4] || c[0] >= c[6] || c[2] >= c[4] || c[2] >= c[6]) &&
                  (c[4] >= c[0] || c[4] >= c[2] || c[6] >= c[0] || c[6] >= c[2]);
  assign meet_y = (c[1] >= c[5] || c[1] >= c[7] || c[3] >= c[5] || c[3] >= c[7]) &&
                  (c[5] >= c[1] || c[5] >= c[3] || c[7] >= c[1] || c[7] >= c[3]);
  assign rng_nxt = meet_x && meet_y;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < sit_pkg::N_CROSS; k++) begin
        ln_dx_r[k] <= ln_dx_nxt[k];
        ln_dy_r[k] <= ln_dy_nxt[k];
        pt_dx_r[k] <= pt_dx_nxt[k];
        pt_dy_r[k] <= pt_dy_nxt[k];
      end
      rng_r <= rng_nxt;
    end
  end

endmodule

/* sv/sit_cross.sv */
// Segment intersection test: one orientation test, products then sign.
// Depends on sit_pkg.
module sit_cross #(
  parameter int unsigned COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  sit_pkg::stage_en_t          en,
  input  logic signed [COORD_WIDTH:0] ln_dx,
  input  logic signed [COORD_WIDTH:0] ln_dy,
  input  logic signed [COORD_WIDTH:0] pt_dx,
  input  logic signed [COORD_WIDTH:0] pt_dy,
  output sit_pkg::sign_t              sgn_r
);

  localparam int unsigned PW = 2*COORD_WIDTH + 2;
  localparam int unsigned VW = PW + 1;

  logic signed [PW-1:0] prod0_nxt, prod1_nxt, prod0_r, prod1_r;
  logic signed [VW-1:0] val;
  sit_pkg::sign_t       sgn_nxt;

  assign prod0_nxt = ln_dy * pt_dx;
  assign prod1_nxt = ln_dx * pt_dy;
  assign val       = VW'(prod0_r) - VW'(prod1_r);

  always_comb begin
    sgn_nxt.neg  = val[VW-1];
    sgn_nxt.zero = (val == '0);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod0_r <= prod0_nxt;
      prod1_r <= prod1_nxt;
    end
    if (en.s3) begin
      sgn_r <= sgn_nxt;
    end
  end

endmodule

/* sv/segment_intersection_test_core.sv */
// Segment intersection test core: top level, stage handshake and final decision.
// Depends on sit_pkg, sit_pre and sit_cross.
//
//  channel | dir | tdata fields (lsb up)                                   | notes
//  in_     | in  | a_start_x a_start_y a_end_x a_end_y b_start_x b_start_y | COORD_WIDTH each
//          |     | b_end_x b_end_y                                         |
//  out_    | out | intersects (bit 0), zero fill to 8 bits                 | one per input word
//
// One word per cycle sustained while out_tready stays high.
// Stages: differences and range compare, eight products, four signs, decision.
// Each stage holds its own valid bit and loads when empty or when the next one moves,
// so bubbles close up and a word is taken while a finished result waits.
// rst_n (synchronous) clears the valid bits only.
module segment_intersection_test_core #(
  parameter int unsigned COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [8*COORD_WIDTH-1:0]         in_tdata,   // a_start_x, a_start_y, a_end_x,
                                                       // a_end_y, b_start_x, b_start_y,
                                                       // b_end_x, b_end_y
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sit_pkg::OUT_TDATA_W-1:0]  out_tdata   // intersects
);

  localparam int unsigned NC = sit_pkg::N_CROSS;

  logic v1_r, v2_r, v3_r, out_tvalid_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic rng1, rng2_r, rng3_r;
  logic out_hit_r, hit_nxt;
  logic same_a, same_b, all_zero;
  sit_pkg::stage_en_t en;
  sit_pkg::sign_t     sg [NC];

  logic signed [COORD_WIDTH:0] ln_dx [NC];
  logic signed [COORD_WIDTH:0] ln_dy [NC];
  logic signed [COORD_WIDTH:0] pt_dx [NC];
  logic signed [COORD_WIDTH:0] pt_dy [NC];

  assign rdy4 = !out_tvalid_r || out_tready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;

  sit_pre #(.COORD_WIDTH(COORD_WIDTH)) u_pre (
    .clk     (clk),
    .en      (rdy1),
    .coords  (in_tdata),
    .ln_dx_r (ln_dx),
    .ln_dy_r (ln_dy),
    .pt_dx_r (pt_dx),
    .pt_dy_r (pt_dy),
    .rng_r   (rng1)
  );

  for (genvar k = 0; k < NC; k++) begin : g_cross
    sit_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
      .clk   (clk),
      .en    (en),
      .ln_dx (ln_dx[k]),
      .ln_dy (ln_dy[k]),
      .pt_dx (pt_dx[k]),
      .pt_dy (pt_dy[k]),
      .sgn_r (sg[k])
    );
  end

  assign same_a   = !sg[0].zero && !sg[1].zero && (sg[0].neg == sg[1].neg);
  assign same_b   = !sg[2].zero && !sg[3].zero && (sg[2].neg == sg[3].neg);
  assign all_zero = sg[0].zero && sg[1].zero && sg[2].zero && sg[3].zero;
  assign hit_nxt  = !(same_a || same_b) && (!all_zero || rng3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) out_tvalid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) rng2_r <= rng1;
    if (rdy3) rng3_r <= rng2_r;
    if (rdy4) out_hit_r <= hit_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(sit_pkg::OUT_TDATA_W-1){1'b0}}, out_hit_r};

endmodule

/* sv/sit_checker.sv */
// Segment intersection test: port-level checks, bound to the top level.
// Depends on segment_intersection_test_core.
module sit_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sit_pkg::OUT_TDATA_W-1:0] out_tdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word present straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed or dropped");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input held off while the output side moves");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[sit_pkg::OUT_TDATA_W-1:1] == '0)
    else $error("fill bits of result word not zero");

  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && out_tvalid && out_tready |-> in_tready)
    else $error("input held off while a result word is taken");

endmodule

bind segment_intersection_test_core sit_checker u_sit_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for segment_intersection_test_core: a directed table of segment pairs, then
// random pairs; V_PRED words predicted with exact 64-bit line values, all checked in order.
// Depends on sit_pkg and segment_intersection_test_core.
module tb_top;

  localparam int CW     = sit_pkg::COORD_WIDTH_DEF;
  localparam int N_DIR  = 20;
  localparam int N_RAND = 1830;

  typedef logic signed [CW-1:0] coord_t;
  // ax1 in the lowest bits, by2 in the highest
  typedef struct packed {
    coord_t by2, bx2, by1, bx1, ay2, ax2, ay1, ax1;
  } seg_pair_t;
  typedef enum int {V_PRED, V_HIT, V_MISS} verdict_t;
  typedef struct packed {
    logic        hit;
    logic [31:0] idx;
  } hit_exp_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [8*CW-1:0]                 in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [sit_pkg::OUT_TDATA_W-1:0] out_tdata;

  verdict_t  tag_q [$];
  hit_exp_t  hit_q [$];
  hit_exp_t  got_exp;
  verdict_t  got_tag;
  int        err_count = 0;
  int        acc_count = 0;
  bit        calm      = 1'b0;

  // ax1 ay1 ax2 ay2 bx1 by1 bx2 by2 verdict
  int dir_tab [N_DIR][9] = '{
    '{0, 0, 10, 10, 0, 10, 10, 0, V_HIT},
    '{0, 0, 10, 0, 0, 1, 10, 1, V_MISS},
    '{0, 0, 5, 5, 5, 5, 10, 0, V_HIT},
    '{0, 0, 10, 0, 5, 0, 5, 7, V_HIT},
    '{0, 0, 10, 0, 5, 0, 15, 0, V_HIT},
    '{0, 0, 4, 0, 5, 0, 9, 0, V_MISS},
    '{0, 0, 5, 0, 5, 0, 9, 0, V_HIT},
    '{3, 3, 3, 3, 0, 0, 6, 6, V_HIT},
    '{8, 8, 8, 8, 0, 0, 6, 6, V_MISS},
    '{7, -2, 7, -2, 7, -2, 7, -2, V_HIT},
    '{7, -2, 7, -2, 7, -1, 7, -1, V_MISS},
    '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, V_HIT},
    '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, V_HIT},
    '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, V_HIT},
    '{-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767, V_MISS},
    '{0, 0, 1, 1, 10, 0, 0, 10, V_PRED},
    '{-32768, 0, -32768, 0, -32768, 0, 32767, 0, V_HIT},
    '{21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846, V_PRED},
    '{0, -10, 0, 10, 0, -5, 0, -20, V_HIT},
    '{0, 0, 1, 1, 2, 2, 3, 3, V_MISS}
  };

  segment_intersection_test_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int sign_of(input longint v);
    if (v > 0) return 1;
    if (v < 0) return -1;
    return 0;
  endfunction

  // side of point (px,py) against the line through (x1,y1)-(x2,y2)
  function automatic int side_of(input longint x1, y1, x2, y2, px, py);
    longint la, lb, lc;
    la = y2 - y1;
    lb = x1 - x2;
    lc = x2 * y1 - x1 * y2;
    return sign_of(la * px + lb * py + lc);
  endfunction

  function automatic bit spans_meet(input longint u1, u2, v1, v2);
    return ((u1 > u2 ? u1 : u2) >= (v1 < v2 ? v1 : v2)) &&
           ((v1 > v2 ? v1 : v2) >= (u1 < u2 ? u1 : u2));
  endfunction

  function automatic logic predict_hit(input seg_pair_t p);
    longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    int     sa1, sa2, sb1, sb2;
    ax1 = p.ax1; ay1 = p.ay1; ax2 = p.ax2; ay2 = p.ay2;
    bx1 = p.bx1; by1 = p.by1; bx2 = p.bx2; by2 = p.by2;
    sa1 = side_of(ax1, ay1, ax2, ay2, bx1, by1);
    sa2 = side_of(ax1, ay1, ax2, ay2, bx2, by2);
    sb1 = side_of(bx1, by1, bx2, by2, ax1, ay1);
    sb2 = side_of(bx1, by1, bx2, by2, ax2, ay2);
    if (sa1 * sa2 > 0 || sb1 * sb2 > 0) return 1'b0;
    if (sa1 == 0 && sa2 == 0 && sb1 == 0 && sb2 == 0)
      return spans_meet(ax1, ax2, bx1, bx2) && spans_meet(ay1, ay2, by1, by2);
    return 1'b1;
  endfunction

  function automatic seg_pair_t pack_xy(input int ax1, ay1, ax2, ay2, bx1, by1, bx2, by2);
    seg_pair_t p;
    p.ax1 = ax1[CW-1:0]; p.ay1 = ay1[CW-1:0];
    p.ax2 = ax2[CW-1:0]; p.ay2 = ay2[CW-1:0];
    p.bx1 = bx1[CW-1:0]; p.by1 = by1[CW-1:0];
    p.bx2 = bx2[CW-1:0]; p.by2 = by2[CW-1:0];
    return p;
  endfunction

  function automatic int span_rand(input int lo_v, input int hi_v);
    return lo_v + int'($urandom_range(0, hi_v - lo_v));
  endfunction

  function automatic int corner_coord();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return span_rand(-32768, 32767);
    endcase
  endfunction

  // mostly collinear runs, shared points and tight clusters; the rest is noise
  function automatic seg_pair_t rand_pair();
    int c [8];
    int bx, by, dx, dy, reach, k0, k1, m;
    bx = span_rand(-20000, 20000);
    by = span_rand(-20000, 20000);
    dx = span_rand(-4, 4);
    dy = span_rand(-4, 4);
    reach = ($urandom_range(0, 1) == 0) ? 6 : 2000;
    case ($urandom_range(0, 9))
      0, 1: begin
        foreach (c[j]) c[j] = int'($urandom);
      end
      2: begin
        foreach (c[j]) c[j] = corner_coord();
      end
      3, 4: begin
        for (int j = 0; j < 8; j += 2) begin
          c[j]   = bx + span_rand(-5, 5);
          c[j+1] = by + span_rand(-5, 5);
        end
      end
      5, 6, 7: begin
        for (int j = 0; j < 8; j += 2) begin
          m      = span_rand(-reach, reach);
          c[j]   = bx + m * dx;
          c[j+1] = by + m * dy;
        end
      end
      default: begin
        k0 = span_rand(-50, 50);
        k1 = span_rand(-50, 50);
        m  = (k0 < k1) ? span_rand(k0, k1) : span_rand(k1, k0);
        c[0] = bx + k0 * dx; c[1] = by + k0 * dy;
        c[2] = bx + k1 * dx; c[3] = by + k1 * dy;
        c[4] = bx + m * dx;  c[5] = by + m * dy;
        c[6] = bx + span_rand(-100, 100);
        c[7] = by + span_rand(-100, 100);
      end
    endcase
    return pack_xy(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endfunction

  task automatic report_miss(input string what);
    err_count++;
    $display("%0t ns mismatch: %s", $time, what);
  endtask

  task automatic send_pair(input seg_pair_t p, input verdict_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tag_q.push_back(want);
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tag_q.size() + hit_q.size() != 0);
  endtask

  // results are checked before the word accepted at the same edge is queued
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (hit_q.size() == 0) begin
          report_miss($sformatf("result word %h with none expected", out_tdata));
        end else begin
          got_exp = hit_q.pop_front();
          if (out_tdata !== {{(sit_pkg::OUT_TDATA_W-1){1'b0}}, got_exp.hit})
            report_miss($sformatf("word %0d: intersects got %h want %b",
                                  got_exp.idx, out_tdata, got_exp.hit));
        end
      end
      if (in_tvalid && in_tready) begin
        got_tag = (tag_q.size() != 0) ? tag_q.pop_front() : V_PRED;
        got_exp.idx = acc_count;
        case (got_tag)
          V_HIT:   got_exp.hit = 1'b1;
          V_MISS:  got_exp.hit = 1'b0;
          default: got_exp.hit = predict_hit(seg_pair_t'(in_tdata));
        endcase
        hit_q.push_back(got_exp);
        acc_count++;
      end
    end
  end

  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_DIR; i++)
      send_pair(pack_xy(dir_tab[i][0], dir_tab[i][1], dir_tab[i][2], dir_tab[i][3],
                        dir_tab[i][4], dir_tab[i][5], dir_tab[i][6], dir_tab[i][7]),
                verdict_t'(dir_tab[i][8]));
    drain();
    for (int i = 0; i < N_RAND; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i == N_RAND / 2) drain();
      send_pair(rand_pair(), V_PRED);
    end
    drain();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
sv/sit_pkg.sv
sv/sit_pre.sv
sv/sit_cross.sv
sv/segment_intersection_test_core.sv
sv/sit_checker.sv
sim/tb_top.sv
